@@ rtl/text_glyph_sprite_layout_unit_defines.svh @@
// Assertion macros shared by the glyph layout RTL.
`ifndef TEXT_GLYPH_SPRITE_LAYOUT_UNIT_DEFINES_SVH
`define TEXT_GLYPH_SPRITE_LAYOUT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TGSL_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TGSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tgsl_pkg.sv @@
// Shared types and constants of the glyph sprite layout unit.
package tgsl_pkg;

    localparam int SCREEN_WIDTH     = 320;
    localparam int NORMAL_LEVEL     = 128;
    localparam int TEXT_BUFFER_SIZE = 200;
    localparam int DIV_STEPS        = 8;

    localparam logic [15:0] HALF_SCREEN  = 16'(SCREEN_WIDTH / 2);
    localparam logic [7:0]  LEVEL_NORMAL = 8'(NORMAL_LEVEL);
    localparam logic [7:0]  LEVEL_STEP   = 8'd8;
    localparam logic [7:0]  TAKEN_LIMIT  = 8'(TEXT_BUFFER_SIZE - 1);

    localparam logic [7:0] CODE_NUL     = 8'd0;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    localparam int MODE_CENTER = 0;
    localparam int MODE_BLEND  = 1;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_END   = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_GLYPH_SIZE     = 3'd0,
        REG_GLYPH_SPACING  = 3'd1,
        REG_FIRST_CODE     = 3'd2,
        REG_GLYPHS_PER_ROW = 3'd3,
        REG_ATLAS_U_ORIGIN = 3'd4,
        REG_ATLAS_V_ORIGIN = 3'd5,
        REG_WIDTH_SHIFT    = 3'd6,
        REG_MODE_FLAGS     = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic        [7:0] glyph_size;
        logic signed [7:0] glyph_spacing;
        logic        [7:0] first_code;
        logic        [7:0] glyphs_per_row;
        logic        [9:0] atlas_u_origin;
        logic        [9:0] atlas_v_origin;
        logic        [2:0] width_shift;
        logic        [1:0] mode_flags;
    } t_cfg;

endpackage

@@ rtl/tgsl_if.sv @@
// Handshake interfaces: character requests, sprite results, register writes.
interface tgsl_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  kind;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic        [7:0]  text_length;
    logic        [7:0]  char_code;

    modport source (output valid, kind, start_x, start_y, text_length, char_code,
                    input ready);
    modport sink   (input valid, kind, start_x, start_y, text_length, char_code,
                    output ready);
endinterface

interface tgsl_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sprite_x;
    logic signed [15:0] sprite_y;
    logic        [15:0] tex_u;
    logic        [15:0] tex_v;
    logic        [7:0]  luminance;

    modport source (output valid, sprite_x, sprite_y, tex_u, tex_v, luminance,
                    input ready);
    modport sink   (input valid, sprite_x, sprite_y, tex_u, tex_v, luminance,
                    output ready);
endinterface

interface tgsl_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] reg_index;
    logic [9:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/tgsl_cfg_regs.sv @@
// Configuration register file of the glyph layout unit.
module tgsl_cfg_regs
    import tgsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tgsl_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_size     <= 8'd8;
            r_cfg.glyph_spacing  <= 8'sd8;
            r_cfg.first_code     <= 8'd32;
            r_cfg.glyphs_per_row <= 8'd16;
            r_cfg.atlas_u_origin <= '0;
            r_cfg.atlas_v_origin <= '0;
            r_cfg.width_shift    <= 3'd3;
            r_cfg.mode_flags     <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_GLYPH_SIZE:     r_cfg.glyph_size     <= i_cfg.wdata[7:0];
                REG_GLYPH_SPACING:  r_cfg.glyph_spacing  <= i_cfg.wdata[7:0];
                REG_FIRST_CODE:     r_cfg.first_code     <= i_cfg.wdata[7:0];
                REG_GLYPHS_PER_ROW: r_cfg.glyphs_per_row <= i_cfg.wdata[7:0];
                REG_ATLAS_U_ORIGIN: r_cfg.atlas_u_origin <= i_cfg.wdata;
                REG_ATLAS_V_ORIGIN: r_cfg.atlas_v_origin <= i_cfg.wdata;
                REG_WIDTH_SHIFT:    r_cfg.width_shift    <= i_cfg.wdata[2:0];
                REG_MODE_FLAGS:     r_cfg.mode_flags     <= i_cfg.wdata[1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/tgsl_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, for the atlas cell.
`include "text_glyph_sprite_layout_unit_defines.svh"
module tgsl_divider
    import tgsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_dividend,
    input  logic [7:0] i_divisor,
    output logic       o_done,
    output logic [7:0] o_quot,
    output logic [7:0] o_rem
);

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_cnt;
    logic [7:0] r_quot;
    logic [7:0] r_rem;
    logic [7:0] r_divisor;
    logic [7:0] r_dividend;
    logic       r_div_zero;

    logic [8:0] trial;
    logic [8:0] diff;
    logic       fits;

    always_comb begin
        trial = {r_rem, r_quot[7]};
        diff  = trial - {1'b0, r_divisor};
        fits  = (trial >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend bits shift out of r_quot as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot     <= i_dividend;
            r_rem      <= '0;
            r_divisor  <= i_divisor;
            r_dividend <= i_dividend;
            r_div_zero <= (i_divisor == 8'd0);
        end else if (r_busy) begin
            r_rem  <= fits ? diff[7:0] : trial[7:0];
            r_quot <= {r_quot[6:0], fits};
        end
    end

    // Zero divisor: everything lands in row 0, column = index.
    assign o_done = r_done;
    assign o_quot = r_div_zero ? 8'd0 : r_quot;
    assign o_rem  = r_div_zero ? r_dividend : r_rem;

    `TGSL_ASSERT(a_no_restart, i_clk, i_rst_n, i_start, !r_busy, "divider restarted while busy")
    `TGSL_ASSERT(a_rem_below, i_clk, i_rst_n, r_done && !r_div_zero, r_rem < r_divisor, "remainder not below divisor")
    `TGSL_ASSERT(a_div_exact, i_clk, i_rst_n, r_done && !r_div_zero, (16'(r_quot) * 16'(r_divisor) + 16'(r_rem)) == 16'(r_dividend), "quotient and remainder do not rebuild dividend")

endmodule

@@ rtl/text_glyph_sprite_layout_unit.sv @@
// Glyph sprite layout unit: character requests in, atlas sprite commands out.
// A request is one of start, character, end or tick. Start, end, tick and the
// characters that draw nothing (space, newline, NUL, anything past the
// 199th character or after a NUL) are taken without leaving ST_IDLE, so the
// unit stays ready. A drawn glyph is accepted in ST_IDLE, which starts the
// one-bit-per-cycle divider that splits the glyph index into atlas column and
// row; ST_DIV waits for the divider's done flag, and in ST_LOAD the u/v
// products are formed and the result register is loaded. That last step waits
// while an earlier result is still unread; a result may sit in the output
// register while the next request is accepted. Configuration writes are taken
// every cycle and must only happen while the unit is idle.
`include "text_glyph_sprite_layout_unit_defines.svh"
module text_glyph_sprite_layout_unit
    import tgsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tgsl_req_if.sink  i_req,
    tgsl_rsp_if.source o_rsp,
    tgsl_cfg_if.sink  i_cfg
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_LOAD = 3'b100
    } t_state;

    t_cfg cfg;

    t_state r_state, n_state;

    // layout state
    logic [15:0] r_pen_x, n_pen_x;
    logic [15:0] r_pen_y, n_pen_y;
    logic [15:0] r_line_x, n_line_x;
    logic [7:0]  r_sprite_level, n_sprite_level;
    logic [7:0]  r_fade_level, n_fade_level;
    logic [7:0]  r_taken, n_taken;
    logic        r_halted, n_halted;

    // glyph in flight
    logic [15:0] r_sx, n_sx;
    logic [15:0] r_sy, n_sy;
    logic [7:0]  r_lum, n_lum;

    // result register
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_sx, r_out_sy, r_out_u, r_out_v;
    logic [7:0]  r_out_lum;

    logic        div_start;
    logic        div_done;
    logic [7:0]  div_quot;
    logic [7:0]  div_rem;
    logic [7:0]  glyph_idx;
    logic        load_out;
    logic [15:0] center_x;
    logic [15:0] start_pos;
    logic [7:0]  glyph_level;
    logic [15:0] prod_u, prod_v;

    tgsl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Index wraps at 8 bits: codes below first_code fold to the top.
    assign glyph_idx = i_req.char_code - cfg.first_code;

    tgsl_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (glyph_idx),
        .i_divisor  (cfg.glyphs_per_row),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        // centred start: half screen minus (length/2) glyph widths, 16-bit wrap
        center_x    = HALF_SCREEN - (16'(i_req.text_length[7:1]) << cfg.width_shift);
        start_pos   = cfg.mode_flags[MODE_CENTER] ? center_x : 16'(i_req.start_x);
        glyph_level = cfg.mode_flags[MODE_BLEND] ? (r_sprite_level + LEVEL_STEP)
                                                 : LEVEL_NORMAL;
        prod_u      = 16'(div_rem) * 16'(cfg.glyph_size);
        prod_v      = 16'(div_quot) * 16'(cfg.glyph_size);
    end

    assign i_req.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state        = r_state;
        n_pen_x        = r_pen_x;
        n_pen_y        = r_pen_y;
        n_line_x       = r_line_x;
        n_sprite_level = r_sprite_level;
        n_fade_level   = r_fade_level;
        n_taken        = r_taken;
        n_halted       = r_halted;
        n_sx           = r_sx;
        n_sy           = r_sy;
        n_lum          = r_lum;
        div_start      = 1'b0;
        load_out       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.kind)
                        KIND_START: begin
                            n_pen_x  = start_pos;
                            n_line_x = start_pos;
                            n_pen_y  = 16'(i_req.start_y);
                            n_taken  = '0;
                            n_halted = 1'b0;
                        end
                        KIND_END: begin
                            if (cfg.mode_flags[MODE_BLEND]) begin
                                n_sprite_level = r_fade_level;
                            end
                        end
                        KIND_TICK: begin
                            n_fade_level = r_fade_level - LEVEL_STEP;
                        end
                        KIND_CHAR: begin
                            // text buffer holds 199 characters; NUL ends the text
                            if (!r_halted && (r_taken < TAKEN_LIMIT)) begin
                                n_taken = r_taken + 8'd1;
                                if (i_req.char_code == CODE_NUL) begin
                                    n_halted = 1'b1;
                                end else if (i_req.char_code == CODE_SPACE) begin
                                    n_pen_x = r_pen_x + 16'(cfg.glyph_size);
                                end else if (i_req.char_code == CODE_NEWLINE) begin
                                    n_pen_x = r_line_x;
                                    n_pen_y = r_pen_y + 16'(cfg.glyph_size);
                                end else begin
                                    // sprite sits at the pen before the advance
                                    n_sx           = r_pen_x;
                                    n_sy           = r_pen_y;
                                    n_sprite_level = glyph_level;
                                    n_lum          = glyph_level;
                                    n_pen_x        = r_pen_x + 16'(cfg.glyph_spacing);
                                    div_start      = 1'b1;
                                    n_state        = ST_DIV;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // hold until the result register is free
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_valid = load_out | (r_out_valid & ~o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_pen_x        <= '0;
            r_pen_y        <= '0;
            r_line_x       <= '0;
            r_sprite_level <= LEVEL_NORMAL;
            r_fade_level   <= '0;
            r_taken        <= '0;
            r_halted       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_pen_x        <= n_pen_x;
            r_pen_y        <= n_pen_y;
            r_line_x       <= n_line_x;
            r_sprite_level <= n_sprite_level;
            r_fade_level   <= n_fade_level;
            r_taken        <= n_taken;
            r_halted       <= n_halted;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx  <= n_sx;
        r_sy  <= n_sy;
        r_lum <= n_lum;
        if (load_out) begin
            r_out_sx  <= r_sx;
            r_out_sy  <= r_sy;
            r_out_u   <= prod_u + 16'(cfg.atlas_u_origin);
            r_out_v   <= prod_v + 16'(cfg.atlas_v_origin);
            r_out_lum <= r_lum;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.sprite_x  = r_out_sx;
    assign o_rsp.sprite_y  = r_out_sy;
    assign o_rsp.tex_u     = r_out_u;
    assign o_rsp.tex_v     = r_out_v;
    assign o_rsp.luminance = r_out_lum;

    `TGSL_ASSERT_NEXT(a_start_to_div, i_clk, i_rst_n, div_start, r_state == ST_DIV, "divider started without entering divide state")
    `TGSL_ASSERT(a_taken_cap, i_clk, i_rst_n, 1'b1, r_taken <= TAKEN_LIMIT, "character count beyond buffer limit")
    `TGSL_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, load_out, r_out_valid && (r_out_lum == $past(r_lum)), "loaded result not presented")
    `TGSL_ASSERT(a_done_in_div, i_clk, i_rst_n, div_done, r_state == ST_DIV, "divider finished outside divide state")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the glyph sprite layout unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tgsl_pkg::*;

    // GLYPH_LATENCY is the time one drawn glyph spends inside the unit; after the
    // last sprite the drain waits DRAIN_CYCLES before touching registers or ending the run.
    localparam int GLYPH_LATENCY = 11;
    localparam int DRAIN_CYCLES  = 3 * GLYPH_LATENCY;
    localparam int IDLE_PERCENT  = 29;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 185;
    // Time limit of the whole run, in nanoseconds, as a guard against a hang.
    localparam longint RUN_LIMIT_NS = 1_000_000;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic        [7:0]  text_length;
        logic        [7:0]  char_code;
    } t_text_req;

    typedef struct packed {
        logic signed [15:0] sprite_x;
        logic signed [15:0] sprite_y;
        logic        [15:0] tex_u;
        logic        [15:0] tex_v;
        logic        [7:0]  luminance;
    } t_sprite;

    // Layout predictor plus the queue of sprites it says are still owed.
    class glyph_sprite_scoreboard;
        t_cfg        cfg;
        logic [15:0] pen_x;
        logic [15:0] pen_y;
        logic [15:0] line_x;
        logic [7:0]  sprite_level;
        logic [7:0]  fade_level;
        int          chars_taken;
        bit          halted;
        t_sprite     pending_sprites[$];
        int          errors;

        function new();
            cfg = '{glyph_size: 8'd8, glyph_spacing: 8'sd8, first_code: 8'd32,
                    glyphs_per_row: 8'd16, atlas_u_origin: 10'd0, atlas_v_origin: 10'd0,
                    width_shift: 3'd3, mode_flags: 2'd0};
            pen_x        = '0;
            pen_y        = '0;
            line_x       = '0;
            sprite_level = LEVEL_NORMAL;
            fade_level   = '0;
            chars_taken  = 0;
            halted       = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(t_reg_index idx, logic [9:0] data);
            case (idx)
                REG_GLYPH_SIZE:     cfg.glyph_size     = data[7:0];
                REG_GLYPH_SPACING:  cfg.glyph_spacing  = data[7:0];
                REG_FIRST_CODE:     cfg.first_code     = data[7:0];
                REG_GLYPHS_PER_ROW: cfg.glyphs_per_row = data[7:0];
                REG_ATLAS_U_ORIGIN: cfg.atlas_u_origin = data;
                REG_ATLAS_V_ORIGIN: cfg.atlas_v_origin = data;
                REG_WIDTH_SHIFT:    cfg.width_shift    = data[2:0];
                REG_MODE_FLAGS:     cfg.mode_flags     = data[1:0];
                default: ;
            endcase
        endfunction

        // Advance the layout state by one accepted request, queue any sprite.
        function void note_request(t_text_req r);
            logic [15:0] x;
            logic [15:0] half_len;
            logic [7:0]  idx;
            logic [7:0]  col;
            logic [7:0]  row;
            logic [31:0] u_sum;
            logic [31:0] v_sum;
            t_sprite     s;
            case (r.kind)
                KIND_START: begin
                    x = r.start_x;
                    if (cfg.mode_flags[MODE_CENTER]) begin
                        half_len = 16'(r.text_length >> 1);
                        x = HALF_SCREEN - (half_len << cfg.width_shift);
                    end
                    pen_x       = x;
                    line_x      = x;
                    pen_y       = r.start_y;
                    chars_taken = 0;
                    halted      = 1'b0;
                end
                KIND_END: begin
                    if (cfg.mode_flags[MODE_BLEND]) sprite_level = fade_level;
                end
                KIND_TICK: begin
                    fade_level = fade_level - LEVEL_STEP;
                end
                default: begin
                    // past the text buffer or after a NUL: dropped silently
                    if (halted || chars_taken >= int'(TAKEN_LIMIT)) return;
                    chars_taken++;
                    if (r.char_code == CODE_NUL) begin
                        halted = 1'b1;
                    end else if (r.char_code == CODE_SPACE) begin
                        pen_x = pen_x + {8'd0, cfg.glyph_size};
                    end else if (r.char_code == CODE_NEWLINE) begin
                        pen_x = line_x;
                        pen_y = pen_y + {8'd0, cfg.glyph_size};
                    end else begin
                        idx = r.char_code - cfg.first_code;
                        // zero glyphs per row: everything sits in row 0
                        if (cfg.glyphs_per_row == 8'd0) begin
                            col = idx;
                            row = 8'd0;
                        end else begin
                            col = idx % cfg.glyphs_per_row;
                            row = idx / cfg.glyphs_per_row;
                        end
                        if (cfg.mode_flags[MODE_BLEND]) sprite_level = sprite_level + LEVEL_STEP;
                        else                            sprite_level = LEVEL_NORMAL;
                        u_sum = {24'd0, col} * {24'd0, cfg.glyph_size}
                              + {22'd0, cfg.atlas_u_origin};
                        v_sum = {24'd0, row} * {24'd0, cfg.glyph_size}
                              + {22'd0, cfg.atlas_v_origin};
                        s.sprite_x  = pen_x;
                        s.sprite_y  = pen_y;
                        s.tex_u     = u_sum[15:0];
                        s.tex_v     = v_sum[15:0];
                        s.luminance = sprite_level;
                        pending_sprites.push_back(s);
                        pen_x = pen_x + {{8{cfg.glyph_spacing[7]}}, cfg.glyph_spacing};
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_sprite(t_sprite got);
            t_sprite want;
            if (pending_sprites.size() == 0) begin
                $error("unexpected sprite x=%0d y=%0d u=%0d v=%0d lum=%0d",
                       got.sprite_x, got.sprite_y, got.tex_u, got.tex_v, got.luminance);
                errors++;
                return;
            end
            want = pending_sprites.pop_front();
            compare_field("sprite_x",  32'(want.sprite_x), 32'(got.sprite_x));
            compare_field("sprite_y",  32'(want.sprite_y), 32'(got.sprite_y));
            compare_field("tex_u",     {16'd0, want.tex_u}, {16'd0, got.tex_u});
            compare_field("tex_v",     {16'd0, want.tex_v}, {16'd0, got.tex_v});
            compare_field("luminance", {24'd0, want.luminance}, {24'd0, got.luminance});
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tgsl_req_if req_if ();
    tgsl_rsp_if rsp_if ();
    tgsl_cfg_if cfg_if ();

    text_glyph_sprite_layout_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    glyph_sprite_scoreboard sb = new();

    // calm: neither side idles; stall_armed: receiver does one long hold-off
    bit calm        = 1'b0;
    bit stall_armed = 1'b0;
    int requests_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the unit hangs somewhere.
    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Sprite receiver: checks accepted sprites, then picks the next ready.
    // Both happen on the sampled (pre-edge) values of the same clock edge.
    initial begin : sprite_receiver
        int  hold_left;
        bit  stall_done;
        hold_left  = 0;
        stall_done = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                sb.check_sprite('{sprite_x: rsp_if.sprite_x, sprite_y: rsp_if.sprite_y,
                                  tex_u: rsp_if.tex_u, tex_v: rsp_if.tex_v,
                                  luminance: rsp_if.luminance});
            end
            if (stall_armed && !stall_done) begin
                hold_left  = LONG_HOLD;
                stall_done = 1'b1;
            end
            if (hold_left > 0) begin
                // long back-pressure: the unit's result register fills and
                // it must stop taking character requests
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    function automatic t_text_req make_request(t_kind kind, logic [15:0] x, logic [15:0] y,
                                               logic [7:0] len, logic [7:0] code);
        t_text_req r;
        r.kind        = kind;
        r.start_x     = x;
        r.start_y     = y;
        r.text_length = len;
        r.char_code   = code;
        return r;
    endfunction

    // Unused payload fields are randomized too, so every bit moves.
    function automatic t_text_req random_request(t_kind kind, logic [7:0] code);
        return make_request(kind, 16'($urandom), 16'($urandom), 8'($urandom), code);
    endfunction

    // Offer one request; returns at the edge where it was taken.
    task automatic send_request(t_text_req r);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= r.kind;
        req_if.start_x     <= r.start_x;
        req_if.start_y     <= r.start_y;
        req_if.text_length <= r.text_length;
        req_if.char_code   <= r.char_code;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
        requests_sent++;
    endtask

    // Leaves valid high; the caller drops it after the last write.
    task automatic write_reg(t_reg_index idx, logic [9:0] data);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata     <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, data);
    endtask

    task automatic write_config(t_cfg c);
        write_reg(REG_GLYPH_SIZE,     {2'b00, c.glyph_size});
        write_reg(REG_GLYPH_SPACING,  {2'b00, c.glyph_spacing});
        write_reg(REG_FIRST_CODE,     {2'b00, c.first_code});
        write_reg(REG_GLYPHS_PER_ROW, {2'b00, c.glyphs_per_row});
        write_reg(REG_ATLAS_U_ORIGIN, c.atlas_u_origin);
        write_reg(REG_ATLAS_V_ORIGIN, c.atlas_v_origin);
        write_reg(REG_WIDTH_SHIFT,    {7'd0, c.width_shift});
        write_reg(REG_MODE_FLAGS,     {8'd0, c.mode_flags});
        cfg_if.valid <= 1'b0;
    endtask

    // Wait until every owed sprite has come back, then let the unit settle.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending_sprites.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One well-formed text: start, characters, usually an end, a few ticks.
    // Now and then a text runs past the 199-character buffer.
    task automatic send_text();
        int n;
        int pick;
        logic [7:0] code;
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(195, 230) : $urandom_range(0, 24);
        send_request(random_request(KIND_START, 8'($urandom)));
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if      (pick < 62) code = 8'($urandom_range(33, 126));
            else if (pick < 72) code = CODE_SPACE;
            else if (pick < 80) code = CODE_NEWLINE;
            else if (pick < 82) code = CODE_NUL;
            else                code = 8'($urandom);
            send_request(random_request(KIND_CHAR, code));
        end
        if ($urandom_range(0, 9) != 0) send_request(random_request(KIND_END, 8'($urandom)));
        repeat ($urandom_range(0, 3)) send_request(random_request(KIND_TICK, 8'($urandom)));
    endtask

    initial begin : stimulus
        t_cfg c;
        int   target;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.kind      <= KIND_START;
        req_if.start_x   <= '0;
        req_if.start_y   <= '0;
        req_if.text_length <= '0;
        req_if.char_code <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.reg_index <= REG_GLYPH_SIZE;
        cfg_if.wdata     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reset register values written back explicitly
        write_config(sb.cfg);
        // character before any start uses the reset pen
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h41));
        send_request(make_request(KIND_START, 16'h8000, 16'h7fff, 8'd0, 8'd0));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h21));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, CODE_SPACE));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h7e));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, CODE_NEWLINE));
        send_request(make_request(KIND_CHAR, 16'hffff, 16'hffff, 8'hff, 8'hff));
        // code below first_code: glyph index wraps to the top of the atlas
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h1f));
        send_request(make_request(KIND_TICK, 16'd0, 16'd0, 8'd0, 8'd0));
        // end without blend mode does nothing
        send_request(make_request(KIND_END, 16'd0, 16'd0, 8'd0, 8'd0));
        // NUL halts the text: the following glyph is dropped
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, CODE_NUL));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h41));
        send_request(make_request(KIND_START, 16'h7fff, 16'h8000, 8'hff, 8'd0));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h30));
        drain();
        // centring plus blend fade
        write_reg(REG_MODE_FLAGS, 10'd3);
        cfg_if.valid <= 1'b0;
        send_request(make_request(KIND_START, 16'd0, 16'd0, 8'hff, 8'd0));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h41));
        send_request(make_request(KIND_TICK, 16'd0, 16'd0, 8'd0, 8'd0));
        send_request(make_request(KIND_TICK, 16'd0, 16'd0, 8'd0, 8'd0));
        send_request(make_request(KIND_END, 16'd0, 16'd0, 8'd0, 8'd0));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h42));
        // level climbs to 248 here
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h43));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, CODE_NEWLINE));
        // level 248 + 8 wraps to 0
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h44));
        send_request(make_request(KIND_START, 16'd0, 16'd0, 8'd1, 8'd0));
        send_request(make_request(KIND_CHAR, 16'd0, 16'd0, 8'd0, 8'h45));
        drain();

        // ---- random phases, each under its own register setting
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: c = '{glyph_size: 8'd255, glyph_spacing: 8'sd127, first_code: 8'd255,
                         glyphs_per_row: 8'd255, atlas_u_origin: 10'd1023,
                         atlas_v_origin: 10'd1023, width_shift: 3'd7, mode_flags: 2'd3};
                // zero size and zero glyphs per row: space leaves the pen x and newline
                // the pen y in place, all glyphs in row 0
                1: c = '{glyph_size: 8'd0, glyph_spacing: -8'sd128, first_code: 8'd0,
                         glyphs_per_row: 8'd0, atlas_u_origin: 10'd0,
                         atlas_v_origin: 10'd0, width_shift: 3'd0, mode_flags: 2'd0};
                2: c = '{glyph_size: 8'd1, glyph_spacing: -8'sd1, first_code: 8'd32,
                         glyphs_per_row: 8'd1, atlas_u_origin: 10'd512,
                         atlas_v_origin: 10'd1, width_shift: 3'd7, mode_flags: 2'd1};
                default: c = '{glyph_size: 8'($urandom), glyph_spacing: 8'($urandom),
                               first_code: 8'($urandom), glyphs_per_row: 8'($urandom),
                               atlas_u_origin: 10'($urandom), atlas_v_origin: 10'($urandom),
                               width_shift: 3'($urandom), mode_flags: 2'($urandom)};
            endcase
            write_config(c);
            calm        = (p == 3);
            stall_armed = (p == 4);
            target      = requests_sent + PHASE_ITEMS;
            while (requests_sent < target) begin
                // mostly whole texts; some loose requests of any kind
                if ($urandom_range(0, 9) == 0)
                    send_request(random_request(t_kind'($urandom_range(0, 3)), 8'($urandom)));
                else
                    send_text();
            end
            drain();
        end
        calm = 1'b0;

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
